// ===== rtl/core/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared constants and types for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int HUE_W  = 12;
  localparam int LVL_W  = 8;
  localparam int REM_W  = 10;
  localparam int FRAC_W = 18;
  localparam int NUM_W  = LVL_W + FRAC_W;

  localparam logic [HUE_W-1:0]  SECTOR_SPAN = 12'd600;
  localparam logic [LVL_W-1:0]  FULL_SCALE  = 8'd255;
  localparam logic [FRAC_W-1:0] FRAC_DENOM  = 18'd153000;

  // Reciprocal of FRAC_DENOM, rounded up, scaled by 2^RECIP_SHIFT. The
  // error term times the largest numerator stays below 2^RECIP_SHIFT, so
  // the quotient comes out exact without a correction step.
  localparam int              RECIP_SHIFT = 44;
  localparam int              RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_M  = 27'd114981609;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_t;

endpackage

// ===== rtl/core/hsvrgb_ifs.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_ifs
// Valid/ready channel interfaces for HSV input words and RGB result words.
// ----------------------------------------------------------------------------
interface hsvrgb_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] hue_tenths;
  logic [7:0]  sat_level;
  logic [7:0]  val_level;

  modport source (output valid, output hue_tenths, output sat_level,
                  output val_level, input ready);
  modport sink   (input valid, input hue_tenths, input sat_level,
                  input val_level, output ready);
endinterface

interface hsvrgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

// ===== rtl/core/hsvrgb_frac_div.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_frac_div
// Registered division of a numerator by the sector fraction denominator,
// done as a multiplication by its scaled reciprocal.
// ----------------------------------------------------------------------------
module hsvrgb_frac_div
  import hsvrgb_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  output logic [LVL_W-1:0] quo_r
);

  localparam int PROD_W = NUM_W + RECIP_W;

  logic [PROD_W-1:0] prod;
  logic [LVL_W-1:0]  quo_nxt;

  assign prod    = PROD_W'(num) * PROD_W'(RECIP_M);
  assign quo_nxt = prod[RECIP_SHIFT +: LVL_W];

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

endmodule

// ===== rtl/core/hsv_to_rgb_converter_unit.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Five-stage pipelined conversion of one HSV pixel to 8-bit RGB.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while not stalled and returns its RGB word,
// with exact truncating arithmetic. The pipe has five register stages: hue
// split into sector and remainder, the products of saturation, the products
// with value, the division by 153000 through a reciprocal multiplier, and
// the output register. The whole pipe moves together: it advances whenever
// the output register is empty or its word is being taken, so in_word.ready
// follows out_word.ready and a stall holds every stage in place.
module hsv_to_rgb_converter_unit
  import hsvrgb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  hsvrgb_in_if.sink     in_word,
  hsvrgb_out_if.source  out_word
);

  logic adv;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;

  // Stage 1: sector and remainder
  sector_t          sector_nxt, s1_sector_r;
  logic [HUE_W-1:0] base_nxt;
  logic [HUE_W-1:0] rem_full;
  logic [REM_W-1:0] s1_rem_r;
  logic [LVL_W-1:0] s1_sat_r, s1_val_r;

  // Stage 2: saturation products
  logic [REM_W-1:0]  rem_inv;
  logic [LVL_W-1:0]  sat_inv;
  logic [FRAC_W-1:0] s2_qs_r, s2_ts_r;
  logic [2*LVL_W-1:0] s2_pn_r;
  logic [LVL_W-1:0]  s2_val_r;
  sector_t           s2_sector_r;

  // Stage 3: value products and p
  logic [FRAC_W-1:0]  qd, td;
  logic [NUM_W-1:0]   s3_nq_r, s3_nt_r;
  logic [2*LVL_W:0]   pn_inc;
  logic [3*LVL_W:0]   p_prod;
  logic [LVL_W-1:0]   s3_p_r, s3_val_r;
  sector_t            s3_sector_r;

  // Stage 4: quotients
  logic [LVL_W-1:0] s4_q_r, s4_t_r, s4_p_r, s4_val_r;
  sector_t          s4_sector_r;

  // Stage 5: output
  logic [LVL_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [LVL_W-1:0] red_r, green_r, blue_r;

  assign adv           = out_word.ready || !out_vld_r;
  assign in_word.ready = adv;

  // Hue is split by comparing against sector boundaries. The seventh
  // range, beyond a full turn, wraps to sector zero.
  always_comb begin
    if (in_word.hue_tenths >= HUE_W'(6 * SECTOR_SPAN)) begin
      sector_nxt = SECTOR_0;
      base_nxt   = HUE_W'(6 * SECTOR_SPAN);
    end else if (in_word.hue_tenths >= HUE_W'(5 * SECTOR_SPAN)) begin
      sector_nxt = SECTOR_5;
      base_nxt   = HUE_W'(5 * SECTOR_SPAN);
    end else if (in_word.hue_tenths >= HUE_W'(4 * SECTOR_SPAN)) begin
      sector_nxt = SECTOR_4;
      base_nxt   = HUE_W'(4 * SECTOR_SPAN);
    end else if (in_word.hue_tenths >= HUE_W'(3 * SECTOR_SPAN)) begin
      sector_nxt = SECTOR_3;
      base_nxt   = HUE_W'(3 * SECTOR_SPAN);
    end else if (in_word.hue_tenths >= HUE_W'(2 * SECTOR_SPAN)) begin
      sector_nxt = SECTOR_2;
      base_nxt   = HUE_W'(2 * SECTOR_SPAN);
    end else if (in_word.hue_tenths >= SECTOR_SPAN) begin
      sector_nxt = SECTOR_1;
      base_nxt   = SECTOR_SPAN;
    end else begin
      sector_nxt = SECTOR_0;
      base_nxt   = '0;
    end
  end

  assign rem_full = in_word.hue_tenths - base_nxt;

  assign rem_inv = REM_W'(SECTOR_SPAN) - s1_rem_r;
  assign sat_inv = FULL_SCALE - s1_sat_r;

  assign qd = FRAC_DENOM - s2_qs_r;
  assign td = FRAC_DENOM - s2_ts_r;

  // Division by 255 of a value up to 255*255: (x + 1) * 257 / 2^16.
  assign pn_inc = {1'b0, s2_pn_r} + 17'd1;
  assign p_prod = {pn_inc, 8'd0} + {8'd0, pn_inc};

  always_comb begin
    case (s4_sector_r)
      SECTOR_0: begin
        red_nxt = s4_val_r; green_nxt = s4_t_r;   blue_nxt = s4_p_r;
      end
      SECTOR_1: begin
        red_nxt = s4_q_r;   green_nxt = s4_val_r; blue_nxt = s4_p_r;
      end
      SECTOR_2: begin
        red_nxt = s4_p_r;   green_nxt = s4_val_r; blue_nxt = s4_t_r;
      end
      SECTOR_3: begin
        red_nxt = s4_p_r;   green_nxt = s4_q_r;   blue_nxt = s4_val_r;
      end
      SECTOR_4: begin
        red_nxt = s4_t_r;   green_nxt = s4_p_r;   blue_nxt = s4_val_r;
      end
      default: begin
        red_nxt = s4_val_r; green_nxt = s4_p_r;   blue_nxt = s4_q_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_word.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sector_r <= sector_nxt;
      s1_rem_r    <= rem_full[REM_W-1:0];
      s1_sat_r    <= in_word.sat_level;
      s1_val_r    <= in_word.val_level;

      s2_qs_r     <= FRAC_W'(s1_rem_r) * FRAC_W'(s1_sat_r);
      s2_ts_r     <= FRAC_W'(rem_inv) * FRAC_W'(s1_sat_r);
      s2_pn_r     <= {{LVL_W{1'b0}}, s1_val_r} * {{LVL_W{1'b0}}, sat_inv};
      s2_val_r    <= s1_val_r;
      s2_sector_r <= s1_sector_r;

      s3_nq_r     <= NUM_W'(s2_val_r) * NUM_W'(qd);
      s3_nt_r     <= NUM_W'(s2_val_r) * NUM_W'(td);
      s3_p_r      <= p_prod[2*LVL_W +: LVL_W];
      s3_val_r    <= s2_val_r;
      s3_sector_r <= s2_sector_r;

      s4_p_r      <= s3_p_r;
      s4_val_r    <= s3_val_r;
      s4_sector_r <= s3_sector_r;

      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
    end
  end

  hsvrgb_frac_div u_div_q (
    .clk   (clk),
    .en    (adv),
    .num   (s3_nq_r),
    .quo_r (s4_q_r)
  );

  hsvrgb_frac_div u_div_t (
    .clk   (clk),
    .en    (adv),
    .num   (s3_nt_r),
    .quo_r (s4_t_r)
  );

  assign out_word.valid = out_vld_r;
  assign out_word.red   = red_r;
  assign out_word.green = green_r;
  assign out_word.blue  = blue_r;

  // A word taken at the input must occupy the first stage next cycle.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready |=> s1_vld_r)
    else $error("accepted word did not enter the first stage");

  // While the pipe is held, no stage may gain or lose a word.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r}))
    else $error("pipe valid bits changed during a stall");

  // The remainder within a sector is always below one sector span.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> s1_rem_r < REM_W'(SECTOR_SPAN))
    else $error("sector remainder out of range");

  // The smaller channels never exceed the value channel.
  a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r |-> s4_p_r <= s4_val_r && s4_q_r <= s4_val_r && s4_t_r <= s4_val_r)
    else $error("derived channel exceeds value level");

endmodule
